/* src/size_class_buffer_pool_unit_assert.svh */
// assertion macros used by the buffer pool controller
`ifndef SIZE_CLASS_BUFFER_POOL_UNIT_ASSERT_SVH
`define SIZE_CLASS_BUFFER_POOL_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define SCBP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SCBP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/scbp_pkg.sv */
// shared types and constants of the size class buffer pool
`timescale 1ns / 1ps

package scbp_pkg;

    localparam int DEF_MAX_CLASSES = 8;
    localparam int DEF_MAX_BUFFERS = 16;

    localparam int OP_W     = 2;
    localparam int REQ_W    = 32;
    localparam int HANDLE_W = 7;
    localparam int STAT_W   = 3;
    localparam int SIZE_W   = 48;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK         = 3'd0;
    localparam logic [STAT_W-1:0] STAT_NONE_FREE  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_WOULD_WAIT = 3'd2;
    localparam logic [STAT_W-1:0] STAT_TOO_LARGE  = 3'd3;
    localparam logic [STAT_W-1:0] STAT_BAD_HANDLE = 3'd4;
    localparam logic [STAT_W-1:0] STAT_CLASS_FULL = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MULTIPLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLASSES    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BUFFERS    = 2'd3;

    // configuration reset values
    localparam logic [31:0] RST_FIRST_SIZE = 32'd4096;
    localparam logic [4:0]  RST_MULTIPLE   = 5'd2;
    localparam logic [3:0]  RST_CLASSES    = 4'd8;
    localparam logic [4:0]  RST_BUFFERS    = 5'd16;

    // datapath to controller
    typedef struct packed {
        logic is_release;
        logic is_try;
        logic any_class;
        logic walk_end;
        logic fits;
        logic fitted;
        logic has_free;
        logic rem_in_class;
        logic class_full;
        logic out_free;
    } scbp_stat_t;

    // controller to datapath
    typedef struct packed {
        logic              load;
        logic              advance;
        logic              rd_issue;
        logic              grant;
        logic              push;
        logic              emit;
        logic [STAT_W-1:0] status;
    } scbp_cmd_t;

endpackage

/* src/scbp_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps

module scbp_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* src/scbp_datapath.sv */
// config registers, class walk datapath, stack pointers and result register
`timescale 1ns / 1ps

module scbp_datapath import scbp_pkg::*; #(
    parameter int MAX_CLASSES = DEF_MAX_CLASSES,
    parameter int MAX_BUFFERS = DEF_MAX_BUFFERS,
    localparam int SLOT_W = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1,
    localparam int DEPTH  = MAX_CLASSES * MAX_BUFFERS,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [OP_W-1:0]       s_opcode,
    input  logic [REQ_W-1:0]      s_request_size,
    input  logic                  s_any_class,
    input  logic [HANDLE_W-1:0]   s_buffer_handle,
    input  logic                  m_ready,
    output logic                  m_valid,
    output logic [STAT_W-1:0]     m_status,
    output logic [HANDLE_W-1:0]   m_granted_handle,
    output logic                  m_granted_valid,
    output logic [SIZE_W-1:0]     m_granted_size,
    input  scbp_cmd_t             cmd,
    output scbp_stat_t            stat,
    output logic                  ram_we,
    output logic [ADDR_W-1:0]     ram_waddr,
    output logic [SLOT_W-1:0]     ram_wdata,
    output logic                  ram_re,
    output logic [ADDR_W-1:0]     ram_raddr,
    input  logic [SLOT_W-1:0]     ram_rdata
);

    localparam int CLS_W  = $clog2(MAX_CLASSES + 1);
    localparam int CIDX_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int CNT_W  = $clog2(MAX_BUFFERS + 1);
    localparam int CMP_W  = (CNT_W > HANDLE_W) ? CNT_W : HANDLE_W;
    localparam int PROD_W = SIZE_W + 5;

    // configuration
    logic [31:0] first_size_reg;
    logic [4:0]  mult_reg;
    logic [3:0]  classes_reg;
    logic [4:0]  buffers_reg;

    // item under work
    logic                rel_reg;
    logic                try_reg;
    logic                any_reg;
    logic [REQ_W-1:0]    req_reg;
    logic [HANDLE_W-1:0] rem_reg;
    logic [HANDLE_W-1:0] base_reg;
    logic [CLS_W-1:0]    cls_reg;
    logic [SIZE_W-1:0]   size_reg;
    logic                fitted_reg;
    logic [SLOT_W-1:0]   pos_reg;
    logic                pos_hit_reg;

    // per class stack state: popped count and high-water mark of written positions
    logic [CNT_W-1:0] used_reg [MAX_CLASSES];
    logic [CNT_W-1:0] hwm_reg  [MAX_CLASSES];

    // result register
    logic                m_valid_reg;
    logic [STAT_W-1:0]   status_reg;
    logic [HANDLE_W-1:0] ghandle_reg;
    logic                gvalid_reg;
    logic [SIZE_W-1:0]   gsize_reg;

    logic [5:0]          classes_wide;
    logic [8:0]          buffers_wide;
    logic [CLS_W-1:0]    nc_eff;
    logic [CNT_W-1:0]    b_eff;
    logic [4:0]          mult_eff;
    logic [PROD_W-1:0]   prod;
    logic [SIZE_W-1:0]   size_next;
    logic [CIDX_W-1:0]   cidx;
    logic [CNT_W-1:0]    used_cur;
    logic [CNT_W-1:0]    hwm_cur;
    logic [SLOT_W-1:0]   rd_pos;
    logic [SLOT_W-1:0]   wr_pos;
    logic [SLOT_W-1:0]   slot_sel;

    assign classes_wide = 6'(classes_reg);
    assign buffers_wide = 9'(buffers_reg);

    always_comb begin
        if (classes_wide == 6'd0) begin
            nc_eff = CLS_W'(1);
        end else if (classes_wide > 6'(MAX_CLASSES)) begin
            nc_eff = CLS_W'(MAX_CLASSES);
        end else begin
            nc_eff = CLS_W'(classes_wide);
        end
        if (buffers_wide == 9'd0) begin
            b_eff = CNT_W'(1);
        end else if (buffers_wide > 9'(MAX_BUFFERS)) begin
            b_eff = CNT_W'(MAX_BUFFERS);
        end else begin
            b_eff = CNT_W'(buffers_wide);
        end
    end

    assign mult_eff  = (mult_reg < 5'd2) ? 5'd2 : mult_reg;
    assign prod      = PROD_W'(size_reg) * PROD_W'(mult_eff);
    // saturate the next class size at the top of the 48 bit range
    assign size_next = (|prod[PROD_W-1:SIZE_W]) ? SIZE_SAT : prod[SIZE_W-1:0];

    assign cidx     = cls_reg[CIDX_W-1:0];
    assign used_cur = used_reg[cidx];
    assign hwm_cur  = hwm_reg[cidx];
    assign rd_pos   = SLOT_W'(used_cur);
    assign wr_pos   = SLOT_W'(used_cur - CNT_W'(1));
    // positions at or above the high-water mark were never written and hold their reset slot
    assign slot_sel = pos_hit_reg ? ram_rdata : pos_reg;

    assign stat.is_release   = rel_reg;
    assign stat.is_try       = try_reg;
    assign stat.any_class    = any_reg;
    assign stat.walk_end     = (cls_reg >= nc_eff);
    assign stat.fits         = (SIZE_W'(req_reg) <= size_reg);
    assign stat.fitted       = fitted_reg;
    assign stat.has_free     = (used_cur < b_eff);
    assign stat.rem_in_class = (CMP_W'(rem_reg) < CMP_W'(b_eff));
    assign stat.class_full   = (used_cur == '0);
    assign stat.out_free     = !m_valid_reg || m_ready;

    assign ram_re    = cmd.rd_issue;
    assign ram_raddr = ADDR_W'(32'(cidx) * MAX_BUFFERS + 32'(rd_pos));
    assign ram_we    = cmd.push;
    assign ram_waddr = ADDR_W'(32'(cidx) * MAX_BUFFERS + 32'(wr_pos));
    assign ram_wdata = SLOT_W'(rem_reg);

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_size_reg <= RST_FIRST_SIZE;
            mult_reg       <= RST_MULTIPLE;
            classes_reg    <= RST_CLASSES;
            buffers_reg    <= RST_BUFFERS;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_FIRST_SIZE: first_size_reg <= cfg_data[31:0];
                REG_MULTIPLE:   mult_reg       <= cfg_data[4:0];
                REG_CLASSES:    classes_reg    <= cfg_data[3:0];
                REG_BUFFERS:    buffers_reg    <= cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rel_reg    <= s_opcode[1];
            try_reg    <= s_opcode[0];
            any_reg    <= s_any_class;
            req_reg    <= s_request_size;
            rem_reg    <= s_buffer_handle;
            base_reg   <= '0;
            cls_reg    <= '0;
            size_reg   <= SIZE_W'(first_size_reg);
            fitted_reg <= 1'b0;
        end else if (cmd.advance) begin
            cls_reg    <= cls_reg + CLS_W'(1);
            size_reg   <= size_next;
            base_reg   <= base_reg + HANDLE_W'(b_eff);
            fitted_reg <= fitted_reg | stat.fits;
            if (rel_reg) begin
                rem_reg <= rem_reg - HANDLE_W'(b_eff);
            end
        end
        if (cmd.rd_issue) begin
            pos_reg     <= rd_pos;
            pos_hit_reg <= (used_cur < hwm_cur);
        end
    end

    // any configuration write re-forms every class with all buffers free
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_valid) begin
            for (int i = 0; i < MAX_CLASSES; i++) begin
                used_reg[i] <= '0;
                hwm_reg[i]  <= '0;
            end
        end else if (cmd.grant) begin
            used_reg[cidx] <= used_cur + CNT_W'(1);
            if (used_cur == hwm_cur) begin
                hwm_reg[cidx] <= used_cur + CNT_W'(1);
            end
        end else if (cmd.push) begin
            used_reg[cidx] <= used_cur - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            status_reg <= cmd.status;
            if (cmd.grant) begin
                ghandle_reg <= base_reg + HANDLE_W'(slot_sel);
                gvalid_reg  <= 1'b1;
                gsize_reg   <= size_reg;
            end else begin
                ghandle_reg <= '0;
                gvalid_reg  <= 1'b0;
                gsize_reg   <= '0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = status_reg;
    assign m_granted_handle = ghandle_reg;
    assign m_granted_valid  = gvalid_reg;
    assign m_granted_size   = gsize_reg;

endmodule

/* src/scbp_ctrl.sv */
// controller state machine: accept, class walk, stack read, result hand-off
`timescale 1ns / 1ps
`include "size_class_buffer_pool_unit_assert.svh"

module scbp_ctrl import scbp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  scbp_stat_t stat,
    output scbp_cmd_t  cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WALK = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_WALK;
                end
            end
            S_WALK: begin
                if (stat.is_release) begin
                    if (stat.walk_end) begin
                        if (stat.out_free) begin
                            cmd.emit   = 1'b1;
                            cmd.status = STAT_BAD_HANDLE;
                            state_next = S_IDLE;
                        end
                    end else if (stat.rem_in_class) begin
                        if (stat.out_free) begin
                            cmd.emit   = 1'b1;
                            state_next = S_IDLE;
                            if (stat.class_full) begin
                                cmd.status = STAT_CLASS_FULL;
                            end else begin
                                cmd.push   = 1'b1;
                                cmd.status = STAT_OK;
                            end
                        end
                    end else begin
                        cmd.advance = 1'b1;
                    end
                end else begin
                    if (stat.walk_end) begin
                        if (stat.out_free) begin
                            cmd.emit   = 1'b1;
                            cmd.status = stat.fitted ? STAT_NONE_FREE : STAT_TOO_LARGE;
                            state_next = S_IDLE;
                        end
                    end else if (stat.fits && stat.has_free) begin
                        cmd.rd_issue = 1'b1;
                        state_next   = S_READ;
                    end else if (stat.fits && !stat.is_try) begin
                        if (stat.out_free) begin
                            cmd.emit   = 1'b1;
                            cmd.status = STAT_WOULD_WAIT;
                            state_next = S_IDLE;
                        end
                    end else if (stat.fits && !stat.any_class) begin
                        if (stat.out_free) begin
                            cmd.emit   = 1'b1;
                            cmd.status = STAT_NONE_FREE;
                            state_next = S_IDLE;
                        end
                    end else begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            S_READ: begin
                // stack data is held in the ram output register until the result slot frees
                if (stat.out_free) begin
                    cmd.grant  = 1'b1;
                    cmd.emit   = 1'b1;
                    cmd.status = STAT_OK;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

    `SCBP_ASSERT_NEXT(a_load_walk, aclk, aresetn, cmd.load, state_reg == S_WALK, "accepted item did not start the class walk")
    `SCBP_ASSERT_IMPLY(a_read_after_walk, aclk, aresetn, state_reg == S_READ, $past(state_reg) == S_WALK || $past(state_reg) == S_READ, "stack read without a class walk")
    `SCBP_ASSERT_IMPLY(a_pop_legal, aclk, aresetn, cmd.rd_issue, stat.fits && stat.has_free && !stat.walk_end && !stat.is_release, "pop issued on a class that cannot serve")
    `SCBP_ASSERT_IMPLY(a_push_legal, aclk, aresetn, cmd.push, stat.rem_in_class && !stat.class_full && !stat.walk_end, "push into a full or invalid class")

endmodule

/* src/size_class_buffer_pool_unit.sv */
// Size class buffer pool: one result per transfer in, classes walked one per cycle.
// A result is registered when the walk reaches a class that serves or refuses the item, or runs
// past the last class; a grant first reads the stack of its class. s_ready is high only in the
// idle state, so the next item is taken only after the result of the last one is registered,
// and a new result waits while the previous one is held by m_ready low.
// Reset (aresetn low, synchronous) restores the registers and frees every buffer in slot order
`timescale 1ns / 1ps

module size_class_buffer_pool_unit import scbp_pkg::*; #(
    parameter int MAX_CLASSES = DEF_MAX_CLASSES,
    parameter int MAX_BUFFERS = DEF_MAX_BUFFERS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [OP_W-1:0]       s_opcode,
    input  logic [REQ_W-1:0]      s_request_size,
    input  logic                  s_any_class,
    input  logic [HANDLE_W-1:0]   s_buffer_handle,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [STAT_W-1:0]     m_status,
    output logic [HANDLE_W-1:0]   m_granted_handle,
    output logic                  m_granted_valid,
    output logic [SIZE_W-1:0]     m_granted_size
);

    localparam int SLOT_W = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
    localparam int DEPTH  = MAX_CLASSES * MAX_BUFFERS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    scbp_cmd_t         cmd;
    scbp_stat_t        stat;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [SLOT_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [SLOT_W-1:0] ram_rdata;

    scbp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    scbp_datapath #(
        .MAX_CLASSES (MAX_CLASSES),
        .MAX_BUFFERS (MAX_BUFFERS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_opcode         (s_opcode),
        .s_request_size   (s_request_size),
        .s_any_class      (s_any_class),
        .s_buffer_handle  (s_buffer_handle),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_status         (m_status),
        .m_granted_handle (m_granted_handle),
        .m_granted_valid  (m_granted_valid),
        .m_granted_size   (m_granted_size),
        .cmd              (cmd),
        .stat             (stat),
        .ram_we           (ram_we),
        .ram_waddr        (ram_waddr),
        .ram_wdata        (ram_wdata),
        .ram_re           (ram_re),
        .ram_raddr        (ram_raddr),
        .ram_rdata        (ram_rdata)
    );

    // free slot stacks, one row of MAX_BUFFERS positions per class
    scbp_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

/* dv/tb_size_class_buffer_pool_unit.sv */
// testbench for size_class_buffer_pool_unit: directed and random traffic checked against an in-bench pool
`timescale 1ns / 1ps

module tb_size_class_buffer_pool_unit;
    import scbp_pkg::*;

    localparam int NUM_CLASSES        = DEF_MAX_CLASSES;
    localparam int NUM_BUFFERS        = DEF_MAX_BUFFERS;
    localparam int SETTLE_CYCLES      = NUM_CLASSES + 6;
    localparam int STALL_LIMIT        = 1000;
    localparam int ROUNDS_PER_PROFILE = 12;
    localparam int ITEMS_PER_ROUND    = 32;
    localparam int MAX_REPORTS        = 100;

    localparam logic [OP_W-1:0] OP_GET         = 2'd0;
    localparam logic [OP_W-1:0] OP_TRY_GET     = 2'd1;
    localparam logic [OP_W-1:0] OP_RELEASE     = 2'd2;
    localparam logic [OP_W-1:0] OP_RELEASE_ALT = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [HANDLE_W-1:0] handle;
        logic                granted;
        logic [SIZE_W-1:0]   bytes;
    } grant_t;

    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  cfg_valid       = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index       = REG_FIRST_SIZE;
    logic [CFG_DATA_W-1:0] cfg_data        = '0;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic [OP_W-1:0]       s_opcode        = OP_GET;
    logic [REQ_W-1:0]      s_request_size  = '0;
    logic                  s_any_class     = 1'b0;
    logic [HANDLE_W-1:0]   s_buffer_handle = '0;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    logic [STAT_W-1:0]     m_status;
    logic [HANDLE_W-1:0]   m_granted_handle;
    logic                  m_granted_valid;
    logic [SIZE_W-1:0]     m_granted_size;

    // pool state as the block should hold it
    logic [31:0] reg_first_size;
    logic [4:0]  reg_multiple;
    logic [3:0]  reg_classes;
    logic [4:0]  reg_buffers;
    logic [3:0]  free_slots [NUM_CLASSES*NUM_BUFFERS];
    logic [4:0]  free_count [NUM_CLASSES];

    grant_t              expected_grants[$];
    logic [HANDLE_W-1:0] held_handles[$];

    int src_gap_pct    = 0;
    int sink_stall_pct = 0;
    int mismatches     = 0;
    int idle_cycles    = 0;

    size_class_buffer_pool_unit u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_opcode         (s_opcode),
        .s_request_size   (s_request_size),
        .s_any_class      (s_any_class),
        .s_buffer_handle  (s_buffer_handle),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_granted_handle (m_granted_handle),
        .m_granted_valid  (m_granted_valid),
        .m_granted_size   (m_granted_size)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int active_classes();
        if (reg_classes == 0) return 1;
        if (reg_classes > NUM_CLASSES) return NUM_CLASSES;
        return int'(reg_classes);
    endfunction

    function automatic int active_buffers();
        if (reg_buffers == 0) return 1;
        if (reg_buffers > NUM_BUFFERS) return NUM_BUFFERS;
        return int'(reg_buffers);
    endfunction

    // next class size, saturating at the size width
    function automatic logic [SIZE_W-1:0] grow_size(logic [SIZE_W-1:0] bytes);
        logic [SIZE_W-1:0] factor;
        factor = (reg_multiple < 2) ? SIZE_W'(2) : SIZE_W'(reg_multiple);
        if (bytes > SIZE_SAT / factor) return SIZE_SAT;
        return bytes * factor;
    endfunction

    function automatic logic [SIZE_W-1:0] class_bytes(int cls);
        logic [SIZE_W-1:0] bytes;
        bytes = SIZE_W'(reg_first_size);
        for (int c = 0; c < cls; c++) bytes = grow_size(bytes);
        return bytes;
    endfunction

    function automatic void refill_pool();
        for (int c = 0; c < NUM_CLASSES; c++) begin
            free_count[c] = 5'(active_buffers());
            for (int p = 0; p < NUM_BUFFERS; p++) free_slots[c*NUM_BUFFERS+p] = 4'(p);
        end
        held_handles.delete();
    endfunction

    function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_FIRST_SIZE: reg_first_size = data;
            REG_MULTIPLE:   reg_multiple   = data[4:0];
            REG_CLASSES:    reg_classes    = data[3:0];
            REG_BUFFERS:    reg_buffers    = data[4:0];
        endcase
        refill_pool();
    endfunction

    // serves one request against the pool and returns the result it must produce
    function automatic grant_t predict_grant(logic [OP_W-1:0] op, logic [REQ_W-1:0] req,
                                             logic any, logic [HANDLE_W-1:0] handle);
        grant_t            r;
        int                nc;
        int                nb;
        int                cls;
        int                slot;
        int                pos;
        logic [SIZE_W-1:0] bytes;
        logic              fitted;
        nc = active_classes();
        nb = active_buffers();
        r  = '0;
        if (op[1]) begin
            cls  = int'(handle) / nb;
            slot = int'(handle) % nb;
            if (cls >= nc) begin
                r.status = STAT_BAD_HANDLE;
            end else if (free_count[cls] >= nb) begin
                r.status = STAT_CLASS_FULL;
            end else begin
                pos = nb - (int'(free_count[cls]) + 1);
                free_slots[cls*NUM_BUFFERS+pos] = 4'(slot);
                free_count[cls] = free_count[cls] + 5'd1;
                r.status = STAT_OK;
            end
            return r;
        end
        bytes    = SIZE_W'(reg_first_size);
        fitted   = 1'b0;
        r.status = STAT_TOO_LARGE;
        for (cls = 0; cls < nc; cls++) begin
            if (SIZE_W'(req) <= bytes) begin
                fitted = 1'b1;
                if (free_count[cls] > 0) begin
                    pos  = nb - int'(free_count[cls]);
                    slot = int'(free_slots[cls*NUM_BUFFERS+pos]);
                    free_count[cls] = free_count[cls] - 5'd1;
                    r.status  = STAT_OK;
                    r.handle  = HANDLE_W'(cls * nb + slot);
                    r.granted = 1'b1;
                    r.bytes   = bytes;
                    held_handles.push_back(r.handle);
                    return r;
                end
                if (op == OP_GET) begin
                    r.status = STAT_WOULD_WAIT;
                    return r;
                end
                if (!any) begin
                    r.status = STAT_NONE_FREE;
                    return r;
                end
            end
            bytes = grow_size(bytes);
        end
        if (fitted) r.status = STAT_NONE_FREE;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatches < MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
        mismatches++;
    endtask

    // valid stays high after a transfer until the next item or a pause lowers it
    task automatic send_item(logic [OP_W-1:0] op, logic [REQ_W-1:0] req, logic any,
                             logic [HANDLE_W-1:0] handle);
        if ($urandom_range(99) < src_gap_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_gap_pct);
        end
        s_valid         <= 1'b1;
        s_opcode        <= op;
        s_request_size  <= req;
        s_any_class     <= any;
        s_buffer_handle <= handle;
        do @(posedge aclk); while (s_ready !== 1'b1);
        expected_grants.push_back(predict_grant(op, req, any, handle));
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (expected_grants.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        apply_reg(idx, data);
    endtask

    // unused upper data bits carry noise
    task automatic program_pool(logic [31:0] first, logic [4:0] mult, logic [3:0] classes,
                                logic [4:0] bufs);
        logic [31:0] noise;
        settle();
        noise = $urandom;
        write_reg(REG_FIRST_SIZE, first);
        write_reg(REG_MULTIPLE, {noise[31:5], mult});
        write_reg(REG_CLASSES, {noise[27:0], classes});
        write_reg(REG_BUFFERS, {noise[26:0], bufs});
        cfg_valid <= 1'b0;
    endtask

    task automatic test_default_classes();
        send_item(OP_GET, 32'd0, 1'b0, 7'd0);
        send_item(OP_GET, 32'd4096, 1'b0, 7'd0);
        send_item(OP_GET, 32'd4097, 1'b1, 7'h7f);
        send_item(OP_TRY_GET, 32'hffff_ffff, 1'b1, 7'h7f);
        send_item(OP_GET, 32'd524288, 1'b0, 7'd0);
        send_item(OP_RELEASE, 32'd0, 1'b0, 7'd1);
        // lifo: the slot just released comes back first
        send_item(OP_GET, 32'd1, 1'b0, 7'd0);
        send_item(OP_RELEASE, 32'hffff_ffff, 1'b1, 7'd100);
        send_item(OP_RELEASE_ALT, 32'd0, 1'b0, 7'd0);
    endtask

    task automatic test_exhausted_classes();
        program_pool(32'd1, 5'd16, 4'd2, 5'd1);
        send_item(OP_GET, 32'd1, 1'b0, 7'd0);
        send_item(OP_GET, 32'd0, 1'b0, 7'd0);
        send_item(OP_TRY_GET, 32'd1, 1'b0, 7'd0);
        send_item(OP_TRY_GET, 32'd0, 1'b1, 7'd0);
        send_item(OP_TRY_GET, 32'd0, 1'b1, 7'd0);
        send_item(OP_GET, 32'd17, 1'b0, 7'd0);
        send_item(OP_RELEASE, 32'd0, 1'b0, 7'd2);
        send_item(OP_RELEASE, 32'd0, 1'b0, 7'd1);
        send_item(OP_RELEASE_ALT, 32'd0, 1'b0, 7'd1);
    endtask

    // largest first size with a factor of 16: the upper classes saturate
    task automatic test_size_saturation();
        program_pool(32'hffff_ffff, 5'd16, 4'd8, 5'd1);
        for (int i = 0; i < NUM_CLASSES; i++) send_item(OP_TRY_GET, 32'hffff_ffff, 1'b1, 7'd0);
    endtask

    task automatic send_random_item();
        int                  roll;
        int                  cls;
        int                  pick;
        logic [SIZE_W-1:0]   bytes;
        logic [31:0]         cap;
        logic [31:0]         req;
        logic [HANDLE_W-1:0] handle;
        roll = $urandom_range(99);
        if (roll < 10) begin
            send_item(OP_W'($urandom_range(3)), $urandom, 1'($urandom_range(1)),
                      HANDLE_W'($urandom_range(127)));
        end else if (roll < 45 && held_handles.size() != 0) begin
            pick   = $urandom_range(held_handles.size() - 1);
            handle = held_handles[pick];
            held_handles.delete(pick);
            send_item(OP_W'($urandom_range(OP_RELEASE_ALT, OP_RELEASE)), $urandom,
                      1'($urandom_range(1)), handle);
        end else begin
            cls   = $urandom_range(active_classes() - 1);
            bytes = class_bytes(cls);
            cap   = (bytes > SIZE_W'(32'hffff_ffff)) ? 32'hffff_ffff : bytes[31:0];
            case ($urandom_range(3))
                0: req = $urandom_range(cap, 0);
                1: req = cap;
                2: req = (cap == 32'hffff_ffff) ? cap : cap + 32'd1;
                default: req = $urandom;
            endcase
            send_item(OP_W'($urandom_range(1)), req, 1'($urandom_range(1)),
                      HANDLE_W'($urandom_range(127)));
        end
    endtask

    task automatic test_random_traffic(int gap_pct, int stall_pct);
        src_gap_pct    = gap_pct;
        sink_stall_pct = stall_pct;
        for (int r = 0; r < ROUNDS_PER_PROFILE; r++) begin
            case (r)
                0: program_pool(32'd1, 5'd2, 4'd1, 5'd1);
                1: program_pool(32'hffff_ffff, 5'd16, 4'd8, 5'd16);
                // out-of-range settings get clamped
                2: program_pool(32'd0, 5'd0, 4'd0, 5'd0);
                3: program_pool($urandom, 5'd31, 4'd15, 5'd31);
                default: program_pool(
                    ($urandom_range(3) == 0) ? $urandom : $urandom_range(65536, 1),
                    ($urandom_range(4) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16, 2)),
                    ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8, 1)),
                    ($urandom_range(4) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16, 1)));
            endcase
            for (int i = 0; i < ITEMS_PER_ROUND; i++) send_random_item();
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin : result_check
        grant_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (expected_grants.size() == 0) begin
                report_mismatch($sformatf("result transfer with nothing pending, status %0d",
                                          m_status));
            end else begin
                want = expected_grants.pop_front();
                if (m_status !== want.status)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              m_status, want.status));
                if (m_granted_handle !== want.handle)
                    report_mismatch($sformatf("granted_handle got %0d expected %0d",
                                              m_granted_handle, want.handle));
                if (m_granted_valid !== want.granted)
                    report_mismatch($sformatf("granted_valid got %0b expected %0b",
                                              m_granted_valid, want.granted));
                if (m_granted_size !== want.bytes)
                    report_mismatch($sformatf("granted_size got %0h expected %0h",
                                              m_granted_size, want.bytes));
            end
        end
    end

    // ends the run when no transfer of any kind happens for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready === 1'b1) || (cfg_valid && cfg_ready === 1'b1) ||
            (m_valid === 1'b1 && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("size_class_buffer_pool_unit: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        reg_first_size = RST_FIRST_SIZE;
        reg_multiple   = RST_MULTIPLE;
        reg_classes    = RST_CLASSES;
        reg_buffers    = RST_BUFFERS;
        refill_pool();
        src_gap_pct    = 8;
        sink_stall_pct = 53;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_default_classes();
        test_exhausted_classes();
        test_size_saturation();
        test_random_traffic(8, 53);
        test_random_traffic(53, 8);
        test_random_traffic(0, 0);

        settle();
        if (mismatches == 0) begin
            $display("size_class_buffer_pool_unit: match");
        end else begin
            $display("size_class_buffer_pool_unit: mismatch");
        end
        $finish;
    end

endmodule

/* size_class_buffer_pool_unit.f */
+incdir+src
src/scbp_pkg.sv
src/scbp_ram.sv
src/scbp_datapath.sv
src/scbp_ctrl.sv
src/size_class_buffer_pool_unit.sv
dv/tb_size_class_buffer_pool_unit.sv
